[sv/triangle_barycentric_shader_top_assert.svh]
// Assertion macros for the triangle barycentric shader.
`ifndef TRIANGLE_BARYCENTRIC_SHADER_TOP_ASSERT_SVH
`define TRIANGLE_BARYCENTRIC_SHADER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shader assertion failed");

// Next-cycle implication, disabled during reset.
`define TBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shader assertion failed");

`endif

[sv/tbs_pkg.sv]
// Shared types and constants for the triangle barycentric shader.
`timescale 1ns / 1ps
package tbs_pkg;

    localparam int X_BITS_DEF = 10;
    localparam int Y_BITS_DEF = 10;
    localparam int PIX_W      = 10;
    localparam int CHAN_W     = 8;
    localparam int NCHAN      = 3;
    localparam int COLOR_W    = CHAN_W * NCHAN;
    localparam int DIV_STAGES = CHAN_W;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_POS   = 3'd0,
        CFG_B_POS   = 3'd1,
        CFG_C_POS   = 3'd2,
        CFG_A_COLOR = 3'd3,
        CFG_B_COLOR = 3'd4,
        CFG_C_COLOR = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic              covered;
        logic [CHAN_W-1:0] chan0;
        logic [CHAN_W-1:0] chan1;
        logic [CHAN_W-1:0] chan2;
        logic              degenerate;
    } t_result;

    typedef struct packed {
        logic valid;
        logic covered;
        logic degenerate;
    } t_ctl;

endpackage

[sv/triangle_barycentric_shader_top.sv]
// Triangle barycentric shader: coverage test and Gouraud color per pixel.
//
// Requests: drive i_pixel and raise start; a request is taken at every
// clock edge where start is high and busy is low. busy is always low, so
// one pixel may enter every cycle.
// Results: o_result is valid for exactly one cycle while o_valid is high,
// in request order. The receiver cannot stall the block; results must be
// taken when shown.
// Pipeline: 3 stages of edge math, 2 of color products and sums, 8 stages
// of a one-bit-per-stage divider by the triangle area, 1 output register.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (vertex positions A, B, C, then vertex colors A, B, C). Writes reach
// the area path via r_ar0/r_ar1, then r_area; write only while no pixel
// is in flight and before the next request.
// Reset: synchronous on i_rst_n; clears the configuration registers and
// the pipeline valid bits, no pixel results are produced for requests in flight.
`timescale 1ns / 1ps
`include "triangle_barycentric_shader_top_assert.svh"
module triangle_barycentric_shader_top #(
    parameter int X_BITS = tbs_pkg::X_BITS_DEF,
    parameter int Y_BITS = tbs_pkg::Y_BITS_DEF,
    localparam int POS_W = X_BITS + Y_BITS,
    localparam int CFG_W = (POS_W > tbs_pkg::COLOR_W) ? POS_W : tbs_pkg::COLOR_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tbs_pkg::t_pixel               i_pixel,
    output logic                          o_valid,
    output tbs_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic [tbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);

    localparam int AW = X_BITS + Y_BITS + 1;
    localparam int NW = AW + tbs_pkg::CHAN_W;
    localparam int NS = tbs_pkg::DIV_STAGES;

    logic [POS_W-1:0]            r_a_pos, r_b_pos, r_c_pos;
    logic [tbs_pkg::COLOR_W-1:0] r_a_color, r_b_color, r_c_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_pos   <= '0;
            r_b_pos   <= '0;
            r_c_pos   <= '0;
            r_a_color <= '0;
            r_b_color <= '0;
            r_c_color <= '0;
        end else if (i_cfg_we) begin
            unique case (tbs_pkg::t_cfg_index'(i_cfg_index))
                tbs_pkg::CFG_A_POS:   r_a_pos   <= i_cfg_data[POS_W-1:0];
                tbs_pkg::CFG_B_POS:   r_b_pos   <= i_cfg_data[POS_W-1:0];
                tbs_pkg::CFG_C_POS:   r_c_pos   <= i_cfg_data[POS_W-1:0];
                tbs_pkg::CFG_A_COLOR: r_a_color <= i_cfg_data[tbs_pkg::COLOR_W-1:0];
                tbs_pkg::CFG_B_COLOR: r_b_color <= i_cfg_data[tbs_pkg::COLOR_W-1:0];
                tbs_pkg::CFG_C_COLOR: r_c_color <= i_cfg_data[tbs_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    tbs_pkg::t_ctl w_ctl_e, w_ctl_i;
    logic [AW-1:0] w_wa, w_wb, w_wc, w_area_e, w_area_i;
    logic [tbs_pkg::NCHAN-1:0][NW-1:0] w_num;

    tbs_edge #(.X_BITS(X_BITS), .Y_BITS(Y_BITS)) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_px    (X_BITS'(i_pixel.pixel_x)),
        .i_py    (Y_BITS'(i_pixel.pixel_y)),
        .i_a_pos (r_a_pos),
        .i_b_pos (r_b_pos),
        .i_c_pos (r_c_pos),
        .o_ctl   (w_ctl_e),
        .o_wa    (w_wa),
        .o_wb    (w_wb),
        .o_wc    (w_wc),
        .o_area  (w_area_e)
    );

    tbs_interp #(.X_BITS(X_BITS), .Y_BITS(Y_BITS)) u_interp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl_e),
        .i_wa      (w_wa),
        .i_wb      (w_wb),
        .i_wc      (w_wc),
        .i_area    (w_area_e),
        .i_a_color (r_a_color),
        .i_b_color (r_b_color),
        .i_c_color (r_c_color),
        .o_ctl     (w_ctl_i),
        .o_area    (w_area_i),
        .o_num     (w_num)
    );

    tbs_pkg::t_ctl [NS:0] w_ctl_div;
    logic [NS:0][AW-1:0] w_area_div;
    logic [NS:0][tbs_pkg::NCHAN-1:0][NW-1:0] w_rem_div;
    logic [NS:0][tbs_pkg::NCHAN-1:0][tbs_pkg::CHAN_W-1:0] w_quo_div;

    assign w_ctl_div[0]  = w_ctl_i;
    assign w_area_div[0] = w_area_i;
    assign w_rem_div[0]  = w_num;
    assign w_quo_div[0]  = '0;

    for (genvar g = 0; g < NS; g++) begin : g_div
        tbs_div_stage #(.X_BITS(X_BITS), .Y_BITS(Y_BITS), .BIT(NS - 1 - g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl_div[g]),
            .i_area  (w_area_div[g]),
            .i_rem   (w_rem_div[g]),
            .i_quo   (w_quo_div[g]),
            .o_ctl   (w_ctl_div[g+1]),
            .o_area  (w_area_div[g+1]),
            .o_rem   (w_rem_div[g+1]),
            .o_quo   (w_quo_div[g+1])
        );
    end

    tbs_pkg::t_result n_result;
    logic             cov;

    always_comb begin
        cov                 = w_ctl_div[NS].covered;
        n_result.covered    = cov;
        n_result.chan0      = cov ? w_quo_div[NS][0] : '0;
        n_result.chan1      = cov ? w_quo_div[NS][1] : '0;
        n_result.chan2      = cov ? w_quo_div[NS][2] : '0;
        n_result.degenerate = w_ctl_div[NS].degenerate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_ctl_div[NS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_result;
    end

    `TBS_ASSERT_IMP(a_uncov_zero, i_clk, i_rst_n, o_valid && !o_result.covered, (o_result.chan0 == '0) && (o_result.chan1 == '0) && (o_result.chan2 == '0))
    `TBS_ASSERT_IMP(a_degen_uncov, i_clk, i_rst_n, o_valid && o_result.degenerate, !o_result.covered)
    `TBS_ASSERT_NXT(a_div_to_out, i_clk, i_rst_n, w_ctl_div[NS].valid, o_valid)
    `TBS_ASSERT_IMP(a_out_from_div, i_clk, i_rst_n, o_valid, $past(w_ctl_div[NS].valid))

endmodule

[sv/tbs_edge.sv]
// Edge function and signed area pipeline: pixel offsets, products, weights.
`timescale 1ns / 1ps
module tbs_edge #(
    parameter int X_BITS = tbs_pkg::X_BITS_DEF,
    parameter int Y_BITS = tbs_pkg::Y_BITS_DEF,
    localparam int POS_W = X_BITS + Y_BITS,
    localparam int PW    = X_BITS + Y_BITS + 2,
    localparam int EW    = PW + 1,
    localparam int AW    = X_BITS + Y_BITS + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [X_BITS-1:0]  i_px,
    input  logic [Y_BITS-1:0]  i_py,
    input  logic [POS_W-1:0]   i_a_pos,
    input  logic [POS_W-1:0]   i_b_pos,
    input  logic [POS_W-1:0]   i_c_pos,
    output tbs_pkg::t_ctl      o_ctl,
    output logic [AW-1:0]      o_wa,
    output logic [AW-1:0]      o_wb,
    output logic [AW-1:0]      o_wc,
    output logic [AW-1:0]      o_area
);

    logic [X_BITS-1:0] ax, bx, cx;
    logic [Y_BITS-1:0] ay, by, cy;
    logic signed [X_BITS:0] ecx_b, eax_c, ebx_a, ecx_a;
    logic signed [Y_BITS:0] ecy_b, eay_c, eby_a, ecy_a;

    assign ax = i_a_pos[X_BITS-1:0];
    assign bx = i_b_pos[X_BITS-1:0];
    assign cx = i_c_pos[X_BITS-1:0];
    assign ay = i_a_pos[POS_W-1:X_BITS];
    assign by = i_b_pos[POS_W-1:X_BITS];
    assign cy = i_c_pos[POS_W-1:X_BITS];

    assign ecx_b = $signed({1'b0, cx}) - $signed({1'b0, bx});
    assign ecy_b = $signed({1'b0, cy}) - $signed({1'b0, by});
    assign eax_c = $signed({1'b0, ax}) - $signed({1'b0, cx});
    assign eay_c = $signed({1'b0, ay}) - $signed({1'b0, cy});
    assign ebx_a = $signed({1'b0, bx}) - $signed({1'b0, ax});
    assign eby_a = $signed({1'b0, by}) - $signed({1'b0, ay});
    assign ecx_a = $signed({1'b0, cx}) - $signed({1'b0, ax});
    assign ecy_a = $signed({1'b0, cy}) - $signed({1'b0, ay});

    // area path, fed from configuration only
    logic signed [PW-1:0] r_ar0, r_ar1;
    logic signed [EW-1:0] r_area;

    always_ff @(posedge i_clk) begin
        r_ar0  <= ebx_a * ecy_a;
        r_ar1  <= eby_a * ecx_a;
        r_area <= EW'(r_ar0) - EW'(r_ar1);
    end

    // stage 1: pixel offsets
    tbs_pkg::t_ctl r_ctl1, r_ctl2, n_ctl3;
    logic signed [X_BITS:0] r_dpx_b, r_dpx_c, r_dpx_a;
    logic signed [Y_BITS:0] r_dpy_b, r_dpy_c, r_dpy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            o_ctl  <= '0;
        end else begin
            r_ctl1 <= '{valid: i_valid, covered: 1'b0, degenerate: 1'b0};
            r_ctl2 <= r_ctl1;
            o_ctl  <= n_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dpx_b <= $signed({1'b0, i_px}) - $signed({1'b0, bx});
        r_dpx_c <= $signed({1'b0, i_px}) - $signed({1'b0, cx});
        r_dpx_a <= $signed({1'b0, i_px}) - $signed({1'b0, ax});
        r_dpy_b <= $signed({1'b0, i_py}) - $signed({1'b0, by});
        r_dpy_c <= $signed({1'b0, i_py}) - $signed({1'b0, cy});
        r_dpy_a <= $signed({1'b0, i_py}) - $signed({1'b0, ay});
    end

    // stage 2: products
    logic signed [PW-1:0] r_pa0, r_pa1, r_pb0, r_pb1, r_pc0, r_pc1;

    always_ff @(posedge i_clk) begin
        r_pa0 <= ecx_b * r_dpy_b;
        r_pa1 <= ecy_b * r_dpx_b;
        r_pb0 <= eax_c * r_dpy_c;
        r_pb1 <= eay_c * r_dpx_c;
        r_pc0 <= ebx_a * r_dpy_a;
        r_pc1 <= eby_a * r_dpx_a;
    end

    // stage 3: weights, normalized to positive area
    logic signed [EW-1:0] wa, wb, wc, wa_n, wb_n, wc_n, area_n;
    logic                 area_neg, cov;

    always_comb begin
        wa       = EW'(r_pa0) - EW'(r_pa1);
        wb       = EW'(r_pb0) - EW'(r_pb1);
        wc       = EW'(r_pc0) - EW'(r_pc1);
        area_neg = r_area[EW-1];
        wa_n     = area_neg ? -wa : wa;
        wb_n     = area_neg ? -wb : wb;
        wc_n     = area_neg ? -wc : wc;
        area_n   = area_neg ? -r_area : r_area;
        cov      = (r_area != '0) && !wa_n[EW-1] && !wb_n[EW-1] && !wc_n[EW-1];
        n_ctl3   = '{valid: r_ctl2.valid, covered: cov, degenerate: (r_area == '0)};
    end

    always_ff @(posedge i_clk) begin
        o_wa   <= cov ? AW'(wa_n) : '0;
        o_wb   <= cov ? AW'(wb_n) : '0;
        o_wc   <= cov ? AW'(wc_n) : '0;
        o_area <= AW'(area_n);
    end

endmodule

[sv/tbs_interp.sv]
// Color numerator pipeline: weight times channel products, then sums with rounding.
`timescale 1ns / 1ps
module tbs_interp #(
    parameter int X_BITS = tbs_pkg::X_BITS_DEF,
    parameter int Y_BITS = tbs_pkg::Y_BITS_DEF,
    localparam int AW = X_BITS + Y_BITS + 1,
    localparam int NW = AW + tbs_pkg::CHAN_W
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  tbs_pkg::t_ctl                           i_ctl,
    input  logic [AW-1:0]                           i_wa,
    input  logic [AW-1:0]                           i_wb,
    input  logic [AW-1:0]                           i_wc,
    input  logic [AW-1:0]                           i_area,
    input  logic [tbs_pkg::COLOR_W-1:0]             i_a_color,
    input  logic [tbs_pkg::COLOR_W-1:0]             i_b_color,
    input  logic [tbs_pkg::COLOR_W-1:0]             i_c_color,
    output tbs_pkg::t_ctl                           o_ctl,
    output logic [AW-1:0]                           o_area,
    output logic [tbs_pkg::NCHAN-1:0][NW-1:0]       o_num
);

    tbs_pkg::t_ctl r_ctl4;
    logic [AW-1:0] r_area4;
    logic [tbs_pkg::NCHAN-1:0][NW-1:0] r_pa, r_pb, r_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl4 <= '0;
            o_ctl  <= '0;
        end else begin
            r_ctl4 <= i_ctl;
            o_ctl  <= r_ctl4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_area4 <= i_area;
        o_area  <= r_area4;
        for (int k = 0; k < tbs_pkg::NCHAN; k++) begin
            r_pa[k]  <= i_wa * i_a_color[tbs_pkg::CHAN_W*k +: tbs_pkg::CHAN_W];
            r_pb[k]  <= i_wb * i_b_color[tbs_pkg::CHAN_W*k +: tbs_pkg::CHAN_W];
            r_pc[k]  <= i_wc * i_c_color[tbs_pkg::CHAN_W*k +: tbs_pkg::CHAN_W];
            o_num[k] <= r_pa[k] + r_pb[k] + r_pc[k] + NW'(r_area4 >> 1);
        end
    end

endmodule

[sv/tbs_div_stage.sv]
// One restoring division step: resolves one quotient bit for all channels.
`timescale 1ns / 1ps
module tbs_div_stage #(
    parameter int X_BITS = tbs_pkg::X_BITS_DEF,
    parameter int Y_BITS = tbs_pkg::Y_BITS_DEF,
    parameter int BIT    = 0,
    localparam int AW = X_BITS + Y_BITS + 1,
    localparam int NW = AW + tbs_pkg::CHAN_W
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  tbs_pkg::t_ctl                                 i_ctl,
    input  logic [AW-1:0]                                 i_area,
    input  logic [tbs_pkg::NCHAN-1:0][NW-1:0]             i_rem,
    input  logic [tbs_pkg::NCHAN-1:0][tbs_pkg::CHAN_W-1:0] i_quo,
    output tbs_pkg::t_ctl                                 o_ctl,
    output logic [AW-1:0]                                 o_area,
    output logic [tbs_pkg::NCHAN-1:0][NW-1:0]             o_rem,
    output logic [tbs_pkg::NCHAN-1:0][tbs_pkg::CHAN_W-1:0] o_quo
);

    logic [NW-1:0]              dvs;
    logic [tbs_pkg::CHAN_W-1:0] qbit;
    assign dvs  = NW'(i_area) << BIT;
    assign qbit = tbs_pkg::CHAN_W'(1) << BIT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        o_area <= i_area;
        for (int k = 0; k < tbs_pkg::NCHAN; k++) begin
            if (i_rem[k] >= dvs) begin
                o_rem[k] <= i_rem[k] - dvs;
                o_quo[k] <= i_quo[k] | qbit;
            end else begin
                o_rem[k] <= i_rem[k];
                o_quo[k] <= i_quo[k];
            end
        end
    end

endmodule

[test/tb_triangle_barycentric_shader_checker.sv]
// Shading checker: predicts each pixel result and compares it with the block output.
`timescale 1ns / 1ps
module tb_triangle_barycentric_shader_checker #(
    parameter int CFG_W = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  tbs_pkg::t_pixel               i_pixel,
    input  logic                          i_valid,
    input  tbs_pkg::t_result              i_result,
    input  logic                          i_cfg_we,
    input  logic [tbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    output int                            o_errors,
    output int                            o_pending
);

    logic [19:0] vert_pos [3];
    logic [23:0] vert_color [3];
    tbs_pkg::t_result shade_fifo [256];
    int wr_cnt;
    int rd_cnt;

    assign o_pending = wr_cnt - rd_cnt;

    function automatic tbs_pkg::t_result shade_pixel(tbs_pkg::t_pixel pix);
        tbs_pkg::t_result r;
        longint vx [3];
        longint vy [3];
        longint w [3];
        longint px, py, area, num, v;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            vx[i] = vert_pos[i][9:0];
            vy[i] = vert_pos[i][19:10];
        end
        px = pix.pixel_x;
        py = pix.pixel_y;
        area = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vy[1] - vy[0]) * (vx[2] - vx[0]);
        w[0] = (vx[2] - vx[1]) * (py - vy[1]) - (vy[2] - vy[1]) * (px - vx[1]);
        w[1] = (vx[0] - vx[2]) * (py - vy[2]) - (vy[0] - vy[2]) * (px - vx[2]);
        w[2] = (vx[1] - vx[0]) * (py - vy[0]) - (vy[1] - vy[0]) * (px - vx[0]);
        if (area < 0) begin
            area = -area;
            for (int i = 0; i < 3; i++) w[i] = -w[i];
        end
        r.degenerate = (area == 0);
        if (area != 0 && w[0] >= 0 && w[1] >= 0 && w[2] >= 0) begin
            r.covered = 1'b1;
            for (int k = 0; k < 3; k++) begin
                num = 0;
                for (int i = 0; i < 3; i++) num += w[i] * longint'(vert_color[i][8*k +: 8]);
                v = (num + area / 2) / area;
                if (v > 255) v = 255;
                if (v < 0) v = 0;
                case (k)
                    0: r.chan0 = v[7:0];
                    1: r.chan1 = v[7:0];
                    default: r.chan2 = v[7:0];
                endcase
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        tbs_pkg::t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                vert_pos[i] = '0;
                vert_color[i] = '0;
            end
            wr_cnt = 0;
            rd_cnt = 0;
            o_errors = 0;
        end else begin
            if (i_valid) begin
                if (wr_cnt == rd_cnt) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = shade_fifo[rd_cnt[7:0]];
                    rd_cnt++;
                    if (i_result.covered !== want.covered)
                        report_mismatch("covered", i_result.covered, want.covered);
                    if (i_result.chan0 !== want.chan0)
                        report_mismatch("chan0", i_result.chan0, want.chan0);
                    if (i_result.chan1 !== want.chan1)
                        report_mismatch("chan1", i_result.chan1, want.chan1);
                    if (i_result.chan2 !== want.chan2)
                        report_mismatch("chan2", i_result.chan2, want.chan2);
                    if (i_result.degenerate !== want.degenerate)
                        report_mismatch("degenerate", i_result.degenerate, want.degenerate);
                end
            end
            if (i_start && !i_busy) begin
                shade_fifo[wr_cnt[7:0]] = shade_pixel(i_pixel);
                wr_cnt++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tbs_pkg::CFG_A_POS:   vert_pos[0] = i_cfg_data[19:0];
                    tbs_pkg::CFG_B_POS:   vert_pos[1] = i_cfg_data[19:0];
                    tbs_pkg::CFG_C_POS:   vert_pos[2] = i_cfg_data[19:0];
                    tbs_pkg::CFG_A_COLOR: vert_color[0] = i_cfg_data[23:0];
                    tbs_pkg::CFG_B_COLOR: vert_color[1] = i_cfg_data[23:0];
                    tbs_pkg::CFG_C_COLOR: vert_color[2] = i_cfg_data[23:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

[test/tb_triangle_barycentric_shader_top.sv]
// Testbench top: drives pixels and vertex setups into the shader and gives the verdict.
`timescale 1ns / 1ps
module tb_triangle_barycentric_shader_top;

    localparam int CFG_W = 24;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    tbs_pkg::t_pixel               pixel;
    logic                          valid;
    tbs_pkg::t_result              result;
    logic                          cfg_we;
    logic [tbs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]              cfg_data;
    int                            errors;
    int                            pending;
    int                            idle_pct;

    triangle_barycentric_shader_top u_top (
        .i_clk(clk), .i_rst_n(rst_n), .start(start), .busy(busy), .i_pixel(pixel),
        .o_valid(valid), .o_result(result), .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    tb_triangle_barycentric_shader_checker #(.CFG_W(CFG_W)) u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy), .i_pixel(pixel),
        .i_valid(valid), .i_result(result), .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic write_reg(tbs_pkg::t_cfg_index idx, logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_triangle(logic [19:0] a, logic [19:0] b, logic [19:0] c,
                                logic [23:0] ca, logic [23:0] cb, logic [23:0] cc);
        drain_pipe();
        write_reg(tbs_pkg::CFG_A_POS, CFG_W'(a));
        write_reg(tbs_pkg::CFG_B_POS, CFG_W'(b));
        write_reg(tbs_pkg::CFG_C_POS, CFG_W'(c));
        write_reg(tbs_pkg::CFG_A_COLOR, ca);
        write_reg(tbs_pkg::CFG_B_COLOR, cb);
        write_reg(tbs_pkg::CFG_C_COLOR, cc);
        repeat (3) @(negedge clk);
    endtask

    task automatic shade(logic [9:0] x, logic [9:0] y);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        pixel <= '{pixel_x: x, pixel_y: y};
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [19:0] rand_vertex(int span);
        logic [9:0] x, y;
        x = 10'($urandom_range(span));
        y = 10'($urandom_range(span));
        if (span < 1023 && $urandom_range(1)) begin
            x = 10'(1023 - x);
            y = 10'(1023 - y);
        end
        return {y, x};
    endfunction

    initial begin
        logic [19:0] va, vb, vc;
        logic [9:0] lo_x, hi_x, lo_y, hi_y;
        rst_n = 1'b0;
        start = 1'b0;
        pixel = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setup: all vertices at origin, degenerate
        shade(10'd0, 10'd0);
        shade(10'd1023, 10'd1023);
        // full-size triangle, extreme colors, vertices and edges
        set_triangle({10'd0, 10'd0}, {10'd0, 10'd1023}, {10'd1023, 10'd0},
                     24'hFFFFFF, 24'h000000, 24'hFF00FF);
        shade(10'd0, 10'd0);
        shade(10'd1023, 10'd0);
        shade(10'd0, 10'd1023);
        shade(10'd511, 10'd512);
        shade(10'd512, 10'd512);
        shade(10'd1023, 10'd1023);
        shade(10'd300, 10'd0);
        shade(10'd0, 10'd300);
        shade(10'd341, 10'd341);
        start <= 1'b0;
        // opposite winding
        set_triangle({10'd1023, 10'd1023}, {10'd0, 10'd1023}, {10'd1023, 10'd0},
                     24'h123456, 24'hABCDEF, 24'h80FF01);
        shade(10'd1023, 10'd1023);
        shade(10'd600, 10'd600);
        shade(10'd100, 10'd100);
        shade(10'd511, 10'd512);
        start <= 1'b0;
        // collinear vertices
        set_triangle({10'd10, 10'd10}, {10'd20, 10'd20}, {10'd30, 10'd30},
                     24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        shade(10'd20, 10'd20);
        shade(10'd5, 10'd7);
        start <= 1'b0;

        for (int s = 0; s < 30; s++) begin
            idle_pct = (s % 5 == 2) ? 0 : 28;
            if (s % 7 == 6) begin
                va = {10'd0, 10'd0};
                vb = {10'd1023, 10'd1023};
                vc = {10'($urandom_range(1023)), 10'($urandom_range(1023))};
            end else begin
                va = rand_vertex(s % 3 == 0 ? 1023 : 60);
                vb = rand_vertex(s % 3 == 0 ? 1023 : 60);
                vc = (s % 11 == 10) ? va : rand_vertex(s % 3 == 0 ? 1023 : 60);
            end
            set_triangle(va, vb, vc, 24'($urandom), 24'($urandom), 24'($urandom));
            lo_x = va[9:0];   hi_x = va[9:0];
            lo_y = va[19:10]; hi_y = va[19:10];
            for (int i = 0; i < 2; i++) begin
                logic [19:0] v;
                v = i ? vc : vb;
                if (v[9:0] < lo_x) lo_x = v[9:0];
                if (v[9:0] > hi_x) hi_x = v[9:0];
                if (v[19:10] < lo_y) lo_y = v[19:10];
                if (v[19:10] > hi_y) hi_y = v[19:10];
            end
            for (int n = 0; n < 60; n++) begin
                case ($urandom_range(9))
                    0: shade(10'($urandom), 10'($urandom));
                    1: shade(($urandom_range(2) == 0) ? va[9:0]
                             : ($urandom_range(1) ? vb[9:0] : vc[9:0]),
                             ($urandom_range(1) ? va[19:10] : vb[19:10]));
                    default: shade(10'($urandom_range(hi_x, lo_x)),
                                   10'($urandom_range(hi_y, lo_y)));
                endcase
                if (s == 4 && n == 30) begin
                    start <= 1'b0;
                    while (pending != 0) @(negedge clk);
                end
            end
            start <= 1'b0;
        end

        drain_pipe();
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

[sim.f]
+incdir+sv
sv/tbs_pkg.sv
sv/tbs_edge.sv
sv/tbs_interp.sv
sv/tbs_div_stage.sv
sv/triangle_barycentric_shader_top.sv
test/tb_triangle_barycentric_shader_checker.sv
test/tb_triangle_barycentric_shader_top.sv
